[src/fca_pkg.sv]
// Package for the chain allocator: payload types, action codes, sequencer states.
// Used by fca_table, fat_chain_allocator_unit and fca_checker. No dependencies.
package fca_pkg;

  // Marker for an empty directory slot or the end of a chain.
  localparam logic [7:0] ENTRY_NONE = 8'hFF;

  // Directory depth and default sector count.
  localparam int DIR_DEPTH        = 256;
  localparam int SECTOR_COUNT_DEF = 256;

  // Walk counter width: holds up to 256 link steps.
  localparam int CNT_W = 9;

  // Last directory slot that New may hand out.
  localparam logic [7:0] LAST_SLOT = 8'd254;

  // Action codes.
  localparam logic [2:0] ACT_NEW    = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_SIZE   = 3'd2;
  localparam logic [2:0] ACT_LOCATE = 3'd3;
  localparam logic [2:0] ACT_FORMAT = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] file_number;
    logic [7:0] logical_index;
  } fca_in_t;

  typedef struct packed {
    logic [7:0] value;
    logic       failed;
  } fca_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_RD,
    ST_NEW_CHK,
    ST_FS_RD,
    ST_FS_CHK,
    ST_ALLOC,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LOC_STEP,
    ST_LINK,
    ST_TERM,
    ST_RESP
  } fca_state_t;

endpackage

[src/fat_chain_allocator_unit.sv]
// Channel  | Direction | Signals                        | Beat contents
// in       | input     | in_valid, in_ready, in_data    | action, file_number, logical_index
// out      | output    | out_valid, out_ready, out_data | value, failed
//
// One beat in, one beat out; the unit takes a new beat only when its sequencer is idle.
// Every probe of either table is an address state, then a registered-data state. Format
// probes nothing; New probes directory slots in order, Size and Locate step along the links
// of one chain, and Append scans the directory slots, walks every chain found, then walks its
// own chain again. Reset (rst_n, synchronous) and Format empty both tables at once. A waiting
// result does not stop the next beat being accepted.
// Top level of the chain allocator; depends on fca_pkg and fca_table.
module fat_chain_allocator_unit
  import fca_pkg::*;
#(
  parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fca_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fca_out_t out_data
);

  localparam int NAW = $clog2(SECTOR_COUNT);

  fca_state_t state_r, state_nxt;
  logic [2:0]       action_r, action_nxt;
  logic [7:0]       num_r, num_nxt;
  logic [7:0]       loc_r, loc_nxt;
  logic [7:0]       f_r, f_nxt;
  logic [7:0]       s_r, s_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [8:0]       best_r, best_nxt;
  logic             link_r, link_nxt;
  fca_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  fca_out_t         out_data_r, out_data_nxt;

  // Table ports.
  logic           tbl_clr;
  logic           dir_we;
  logic [7:0]     dir_waddr;
  logic [7:0]     dir_wdata;
  logic [7:0]     dir_raddr;
  logic [7:0]     dir_rdata;
  logic           lnk_we;
  logic [NAW-1:0] lnk_waddr;
  logic [7:0]     lnk_wdata;
  logic [NAW-1:0] lnk_raddr;
  logic [7:0]     lnk_rdata;
  logic [8:0]     s_plus1;
  logic           slot_free;

  fca_table #(.DEPTH(DIR_DEPTH), .AW(8)) u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (tbl_clr),
    .wr_en   (dir_we),
    .wr_addr (dir_waddr),
    .wr_data (dir_wdata),
    .rd_addr (dir_raddr),
    .rd_data (dir_rdata)
  );

  fca_table #(.DEPTH(SECTOR_COUNT), .AW(NAW)) u_lnk (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (tbl_clr),
    .wr_en   (lnk_we),
    .wr_addr (lnk_waddr),
    .wr_data (lnk_wdata),
    .rd_addr (lnk_raddr),
    .rd_data (lnk_rdata)
  );

  assign s_plus1   = {1'b0, s_r} + 9'd1;
  assign slot_free = !out_valid_r || out_ready;

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r   <= action_nxt;
    num_r      <= num_nxt;
    loc_r      <= loc_nxt;
    f_r        <= f_nxt;
    s_r        <= s_nxt;
    cnt_r      <= cnt_nxt;
    best_r     <= best_nxt;
    link_r     <= link_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state, table accesses and result selection.
  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    num_nxt       = num_r;
    loc_nxt       = loc_r;
    f_nxt         = f_r;
    s_nxt         = s_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    link_nxt      = link_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    tbl_clr       = 1'b0;
    dir_we        = 1'b0;
    dir_waddr     = num_r;
    dir_wdata     = best_r[7:0];
    dir_raddr     = f_r;
    lnk_we        = 1'b0;
    lnk_waddr     = s_r[NAW-1:0];
    lnk_wdata     = best_r[7:0];
    lnk_raddr     = s_r[NAW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          action_nxt = in_data.action;
          num_nxt    = in_data.file_number;
          loc_nxt    = in_data.logical_index;
          f_nxt      = '0;
          cnt_nxt    = '0;
          best_nxt   = '0;
          link_nxt   = 1'b0;
          res_nxt    = '{value: ENTRY_NONE, failed: 1'b1};
          state_nxt  = ST_RESP;
          case (in_data.action) inside
            ACT_FORMAT: begin
              tbl_clr = 1'b1;
              res_nxt = '{value: 8'd0, failed: 1'b0};
            end
            ACT_NEW: begin
              state_nxt = ST_NEW_RD;
            end
            ACT_APPEND: begin
              if (in_data.file_number != ENTRY_NONE) begin
                state_nxt = ST_FS_RD;
              end
            end
            ACT_SIZE, ACT_LOCATE: begin
              if (in_data.file_number != ENTRY_NONE) begin
                state_nxt = ST_HEAD_RD;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      // New: probe directory slots in order for an empty one.
      ST_NEW_RD: begin
        dir_raddr = f_r;
        state_nxt = ST_NEW_CHK;
      end
      ST_NEW_CHK: begin
        if (dir_rdata == ENTRY_NONE) begin
          res_nxt   = '{value: f_r, failed: 1'b0};
          state_nxt = ST_RESP;
        end else if (f_r == LAST_SLOT) begin
          state_nxt = ST_RESP;
        end else begin
          f_nxt     = f_r + 8'd1;
          state_nxt = ST_NEW_RD;
        end
      end

      // Free-sector scan: read each file's head until the first empty slot.
      ST_FS_RD: begin
        dir_raddr = f_r;
        state_nxt = ST_FS_CHK;
      end
      ST_FS_CHK: begin
        if (dir_rdata == ENTRY_NONE) begin
          state_nxt = ST_ALLOC;
        end else begin
          s_nxt     = dir_rdata;
          cnt_nxt   = '0;
          state_nxt = ST_WALK_RD;
        end
      end

      // Scan finished: the last sector is reserved.
      ST_ALLOC: begin
        if (best_r >= 9'(SECTOR_COUNT - 1)) begin
          state_nxt = ST_RESP;
        end else begin
          link_nxt  = 1'b1;
          state_nxt = ST_HEAD_RD;
        end
      end

      // Head of the addressed file.
      ST_HEAD_RD: begin
        dir_raddr = num_r;
        state_nxt = ST_HEAD_CHK;
      end
      ST_HEAD_CHK: begin
        s_nxt   = dir_rdata;
        cnt_nxt = '0;
        case (action_r)
          ACT_SIZE: begin
            if (dir_rdata == ENTRY_NONE) begin
              res_nxt   = '{value: 8'd0, failed: 1'b0};
              state_nxt = ST_RESP;
            end else begin
              cnt_nxt   = CNT_W'(1);
              state_nxt = ST_WALK_RD;
            end
          end
          ACT_LOCATE: begin
            state_nxt = (dir_rdata == ENTRY_NONE) ? ST_RESP : ST_LOC_STEP;
          end
          default: begin
            // Append: an empty file takes the new sector as its head.
            if (dir_rdata == ENTRY_NONE) begin
              dir_we    = 1'b1;
              dir_waddr = num_r;
              dir_wdata = best_r[7:0];
              state_nxt = ST_TERM;
            end else begin
              state_nxt = ST_WALK_RD;
            end
          end
        endcase
      end

      // One link of a chain walk.
      ST_WALK_RD: begin
        lnk_raddr = s_r[NAW-1:0];
        state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        case (action_r)
          ACT_SIZE: begin
            if (lnk_rdata != ENTRY_NONE && cnt_r < CNT_W'(255)) begin
              s_nxt     = lnk_rdata;
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = ST_WALK_RD;
            end else begin
              res_nxt   = '{value: cnt_r[7:0], failed: 1'b0};
              state_nxt = ST_RESP;
            end
          end
          ACT_LOCATE: begin
            if (lnk_rdata == ENTRY_NONE) begin
              state_nxt = ST_RESP;
            end else begin
              s_nxt     = lnk_rdata;
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = ST_LOC_STEP;
            end
          end
          default: begin
            // Append: find the last sector, bounded by the sector count.
            if (lnk_rdata != ENTRY_NONE && cnt_r < CNT_W'(SECTOR_COUNT)) begin
              s_nxt     = lnk_rdata;
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = ST_WALK_RD;
            end else if (link_r) begin
              state_nxt = ST_LINK;
            end else begin
              if (s_plus1 > best_r) begin
                best_nxt = s_plus1;
              end
              if (f_r == LAST_SLOT) begin
                state_nxt = ST_ALLOC;
              end else begin
                f_nxt     = f_r + 8'd1;
                state_nxt = ST_FS_RD;
              end
            end
          end
        endcase
      end

      // Locate: stop once the logical index is reached.
      ST_LOC_STEP: begin
        if (cnt_r[7:0] == loc_r) begin
          res_nxt   = '{value: s_r, failed: 1'b0};
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end

      // Append: link the new sector behind the last one, then end the chain there.
      ST_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = s_r[NAW-1:0];
        lnk_wdata = best_r[7:0];
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        lnk_we    = 1'b1;
        lnk_waddr = best_r[NAW-1:0];
        lnk_wdata = ENTRY_NONE;
        res_nxt   = '{value: best_r[7:0], failed: 1'b0};
        state_nxt = ST_RESP;
      end

      // Hand the result to the output register once it is free.
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/fca_table.sv]
// One table of 8-bit sector entries with a registered read port and a valid bit per entry.
// An entry never written since reset or the last clear reads as ENTRY_NONE. Uses fca_pkg.
module fca_table
  import fca_pkg::*;
#(
  parameter int DEPTH = DIR_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rd_word_r;
  logic             rd_vld_r;

  // Storage array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_word_r <= mem_r[rd_addr];
  end

  // Valid bits are cleared together by reset or a format.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // An entry that is not valid reads as empty.
  assign rd_data = rd_vld_r ? rd_word_r : ENTRY_NONE;

endmodule

[src/fca_checker.sv]
// Port-level checks for the chain allocator, bound to fat_chain_allocator_unit.
// Depends on fca_pkg for the payload types.
module fca_checker
  import fca_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input fca_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input fca_out_t out_data
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A stalled input beat holds its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> $stable(in_data))
    else $error("input beat changed while stalled");

  // A failed result always carries the empty marker.
  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failed |-> out_data.value == ENTRY_NONE)
    else $error("failed result with a value other than the empty marker");

  // The unit is not ready again directly after taking a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

endmodule

bind fat_chain_allocator_unit fca_checker u_fca_checker (.*);
